// ----- rtl/ffha_pkg.sv -----
// Package: shared constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int ADDR_BITS_DEF = 20;
    localparam int FREE_ENTRIES_DEF = 16;
    localparam int LIVE_ENTRIES_DEF = 16;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MIN_SPLIT_BYTES_DEF = 16;
    localparam int REQ_W = 20;
    localparam int SIZE_W = 21;
    localparam int CFG_IDX_W = 1;
    localparam int ST_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_ENABLE = 1'd1;

    localparam logic [ST_W-1:0] ST_OK = 3'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 3'd1;
    localparam logic [ST_W-1:0] ST_DISABLED = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;
endpackage

// ----- rtl/ffha_if.sv -----
// Interfaces: valid/ready channels for requests and results
`timescale 1ns / 1ps
interface ffha_req_if;
    logic valid;
    logic ready;
    logic action;
    logic [ffha_pkg::REQ_W-1:0] request_size;
    logic [ffha_pkg::REQ_W-1:0] block_address;
    modport source (output valid, action, request_size, block_address, input ready);
    modport sink (input valid, action, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
    logic valid;
    logic ready;
    logic [ffha_pkg::REQ_W-1:0] address;
    logic [ffha_pkg::ST_W-1:0] status;
    modport source (output valid, address, status, input ready);
    modport sink (input valid, address, status, output ready);
endinterface

// ----- rtl/ffha_cell.sv -----
// One table cell: holds a segment, shifts it to the next cell each cycle of a scan
`timescale 1ns / 1ps
module ffha_cell #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         clr,
    input  logic         shift,
    input  logic         in_used,
    input  logic [W-1:0] in_start,
    input  logic [W:0]   in_len,
    input  logic         ld_used,
    input  logic [W-1:0] ld_start,
    input  logic [W:0]   ld_len,
    output logic         used,
    output logic [W-1:0] start,
    output logic [W:0]   len
);
    logic         used_reg;
    logic [W-1:0] start_reg;
    logic [W:0]   len_reg;

    // Clear, load or take the neighbour's entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (clr)
        begin
            used_reg <= 1'b0;
        end
        else if (load)
        begin
            used_reg <= ld_used;
        end
        else if (shift)
        begin
            used_reg <= in_used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg <= ld_start;
            len_reg <= ld_len;
        end
        else if (shift)
        begin
            start_reg <= in_start;
            len_reg <= in_len;
        end
    end

    assign used = used_reg;
    assign start = start_reg;
    assign len = len_reg;
endmodule

// ----- rtl/ffha_ring.sv -----
// Ring of cells: a table that rotates one entry a cycle past a head port while shift is high
`timescale 1ns / 1ps
module ffha_ring #(
    parameter int W = 20,
    parameter int N = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clr,
    input  logic         shift,
    input  logic         init,
    input  logic [W:0]   init_len,
    input  logic         wr,
    input  logic         wr_used,
    input  logic [W-1:0] wr_start,
    input  logic [W:0]   wr_len,
    output logic         head_used,
    output logic [W-1:0] head_start,
    output logic [W:0]   head_len
);
    logic         u [N];
    logic [W-1:0] s [N];
    logic [W:0]   l [N];

    // Cell 0 is the head; on a rotate the tail cell takes the head entry, patched when wr is high
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic         iu;
        logic [W-1:0] is;
        logic [W:0]   il;
        logic         ld;
        logic         lu;
        logic [W-1:0] ls;
        logic [W:0]   ll;
        if (i == N - 1)
        begin : g_tail
            assign iu = wr ? wr_used : u[0];
            assign is = wr ? wr_start : s[0];
            assign il = wr ? wr_len : l[0];
        end
        else
        begin : g_mid
            assign iu = u[i+1];
            assign is = s[i+1];
            assign il = l[i+1];
        end
        assign ld = init;
        assign lu = (i == 0) && (init_len != '0);
        assign ls = '0;
        assign ll = init_len;
        ffha_cell #(.W(W)) u_cell (
            .clk(clk), .rst_n(rst_n), .load(ld), .clr(clr), .shift(shift),
            .in_used(iu), .in_start(is), .in_len(il),
            .ld_used(lu), .ld_start(ls), .ld_len(ll),
            .used(u[i]), .start(s[i]), .len(l[i])
        );
    end

    assign head_used = u[0];
    assign head_start = s[0];
    assign head_len = l[0];
endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level: first-fit heap allocator with coalescing free
// Usage:
//   req channel carries action (0 allocate, 1 free), request_size, block_address.
//   rsp channel returns one word per request: address and status.
//   cfg_we/cfg_idx/cfg_data write heap_size (index 0, rebuilds the tables) and
//   heap_enable (index 1); write only while idle.
// Operation:
//   Both tables are rings of FREE_ENTRIES / LIVE_ENTRIES cells rotating one entry
//   a cycle past a head port; every pass is one full rotation of one ring.
//   Allocate = free ring search, live ring claim, free ring split pass.
//   Free = live ring search, free ring neighbour search, free ring merge, live ring
//   retire. No fit and unknown address answer after one pass, a full table after
//   two; a disabled heap answers with no pass. One request at a time: the next
//   is accepted in the cycle after the result is taken.
// Reset: both tables empty, heap_size 0, heap disabled.
// Stall: the result is held in an output register until taken; the next request
//   is accepted only after that.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
    parameter int HEAP_ADDR_BITS = ffha_pkg::ADDR_BITS_DEF,
    parameter int FREE_ENTRIES = ffha_pkg::FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES = ffha_pkg::LIVE_ENTRIES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ffha_req_if.sink                           req,
    ffha_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [ffha_pkg::SIZE_W-1:0]        cfg_data
);
    import ffha_pkg::*;

    localparam int W = HEAP_ADDR_BITS;
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int LCW = $clog2(LIVE_ENTRIES + 1);
    localparam int CW = (FCW > LCW) ? FCW : LCW;
    localparam logic [W:0] LIMIT = {1'b1, {W{1'b0}}};
    localparam logic [W+1:0] HDR = (W + 2)'(HEADER_BYTES);
    localparam logic [W:0] MINS = (W + 1)'(MIN_SPLIT_BYTES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_AFIND = 9'b000000010,
        S_APAT  = 9'b000000100,
        S_LPAT  = 9'b000001000,
        S_LFIND = 9'b000010000,
        S_FFIND = 9'b000100000,
        S_FPAT  = 9'b001000000,
        S_LCLR  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic enable_reg;
    logic [W-1:0] lo_reg;               // low address bits of request
    logic [W+1:0] need_reg;
    logic fnd_reg, fnd_next;            // fit / block found
    logic [W-1:0] bst_reg, bst_next;    // best start (alloc) or block start (free)
    logic [W:0] bln_reg, bln_next;      // best length or block length
    logic slot_reg, slot_next;          // free slot seen
    logic pred_reg, pred_next, succ_reg, succ_next;
    logic [W:0] sln_reg, sln_next;      // successor length
    logic done_reg, done_next;          // patch already applied this pass
    logic [W-1:0] oaddr_reg;
    logic [ST_W-1:0] ost_reg;
    logic [W-1:0] raddr_next;
    logic [ST_W-1:0] rst_next;
    logic [W-1:0] raddr_reg;
    logic [ST_W-1:0] rstat_reg;
    logic act_reg;

    logic f_shift, f_wr, f_wu, l_shift, l_wr, l_wu, tinit;
    logic [W-1:0] f_ws, l_ws;
    logic [W:0] f_wl, l_wl, init_len;
    logic fu, lu;
    logic [W-1:0] fs, ls;
    logic [W:0] fl, ll;
    logic [W+1:0] fend, bend, rem;
    logic [W-1:0] lkey;

    // Saturate written heap size
    assign init_len = (cfg_data > (SIZE_W)'(LIMIT)) ? LIMIT : (W + 1)'(cfg_data);
    assign tinit = cfg_we && (cfg_idx == REG_HEAP_SIZE);

    ffha_ring #(.W(W), .N(FREE_ENTRIES)) u_free (
        .clk(clk), .rst_n(rst_n), .clr(1'b0), .shift(f_shift), .init(tinit),
        .init_len(init_len), .wr(f_wr), .wr_used(f_wu), .wr_start(f_ws), .wr_len(f_wl),
        .head_used(fu), .head_start(fs), .head_len(fl)
    );
    ffha_ring #(.W(W), .N(LIVE_ENTRIES)) u_live (
        .clk(clk), .rst_n(rst_n), .clr(tinit), .shift(l_shift), .init(1'b0),
        .init_len('0), .wr(l_wr), .wr_used(l_wu), .wr_start(l_ws), .wr_len(l_wl),
        .head_used(lu), .head_start(ls), .head_len(ll)
    );

    assign fend = {1'b0, fl} + {2'b0, fs};
    assign bend = {1'b0, bln_reg} + {2'b0, bst_reg};
    assign rem = {1'b0, bln_reg} - need_reg;
    assign lkey = W'({2'b0, ls} + HDR);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_we && cfg_idx == REG_HEAP_ENABLE)
        begin
            enable_reg <= cfg_data[0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        fnd_next = fnd_reg;
        bst_next = bst_reg;
        bln_next = bln_reg;
        slot_next = slot_reg;
        pred_next = pred_reg;
        succ_next = succ_reg;
        sln_next = sln_reg;
        done_next = done_reg;
        raddr_next = raddr_reg;
        rst_next = rstat_reg;
        f_shift = 1'b0;
        f_wr = 1'b0;
        f_wu = fu;
        f_ws = fs;
        f_wl = fl;
        l_shift = 1'b0;
        l_wr = 1'b0;
        l_wu = lu;
        l_ws = ls;
        l_wl = ll;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                fnd_next = 1'b0;
                slot_next = 1'b0;
                pred_next = 1'b0;
                succ_next = 1'b0;
                done_next = 1'b0;
                raddr_next = '0;
                if (req.valid)
                begin
                    if (!enable_reg)
                    begin
                        rst_next = ST_DISABLED;
                        state_next = S_OUT;
                    end
                    else if (req.action == ACT_ALLOC)
                    begin
                        state_next = S_AFIND;
                    end
                    else
                    begin
                        state_next = S_LFIND;
                    end
                end
            end
            // Find lowest fitting segment
            S_AFIND:
            begin
                f_shift = 1'b1;
                if (fu && {1'b0, fl} >= need_reg && (!fnd_reg || fs < bst_reg))
                begin
                    fnd_next = 1'b1;
                    bst_next = fs;
                    bln_next = fl;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FREE_ENTRIES - 1))
                begin
                    cnt_next = '0;
                    if (!fnd_next)
                    begin
                        rst_next = ST_NOFIT;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LPAT;
                    end
                end
            end
            // Claim first empty live slot
            S_LPAT:
            begin
                l_shift = 1'b1;
                if (!lu && !done_reg)
                begin
                    done_next = 1'b1;
                    l_wr = 1'b1;
                    l_wu = 1'b1;
                    l_ws = bst_reg;
                    l_wl = (rem >= {1'b0, MINS}) ? (W + 1)'(need_reg) : bln_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LIVE_ENTRIES - 1))
                begin
                    cnt_next = '0;
                    if (!done_next)
                    begin
                        rst_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        done_next = 1'b0;
                        state_next = S_APAT;
                    end
                end
            end
            // Split or take the chosen segment
            S_APAT:
            begin
                f_shift = 1'b1;
                if (fu && fs == bst_reg && !done_reg)
                begin
                    done_next = 1'b1;
                    f_wr = 1'b1;
                    if (rem >= {1'b0, MINS})
                    begin
                        f_ws = W'({2'b0, fs} + need_reg);
                        f_wl = (W + 1)'(rem);
                    end
                    else
                    begin
                        f_wu = 1'b0;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FREE_ENTRIES - 1))
                begin
                    rst_next = ST_OK;
                    raddr_next = W'({2'b0, bst_reg} + HDR);
                    state_next = S_OUT;
                end
            end
            // Find the live block by address
            S_LFIND:
            begin
                l_shift = 1'b1;
                if (lu && !fnd_reg && lkey == lo_reg)
                begin
                    fnd_next = 1'b1;
                    bst_next = ls;
                    bln_next = ll;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LIVE_ENTRIES - 1))
                begin
                    cnt_next = '0;
                    if (!fnd_next)
                    begin
                        rst_next = ST_UNKNOWN;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FFIND;
                    end
                end
            end
            // Look for neighbours and a free slot
            S_FFIND:
            begin
                f_shift = 1'b1;
                if (!fu)
                begin
                    slot_next = 1'b1;
                end
                else if (fend == {1'b0, bst_reg})
                begin
                    pred_next = 1'b1;
                end
                else if ({1'b0, fs} == bend[W:0])
                begin
                    succ_next = 1'b1;
                    sln_next = fl;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FREE_ENTRIES - 1))
                begin
                    cnt_next = '0;
                    if (!pred_next && !succ_next && !slot_next)
                    begin
                        rst_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FPAT;
                    end
                end
            end
            // Merge or insert the block
            S_FPAT:
            begin
                f_shift = 1'b1;
                if (fu && fend == {1'b0, bst_reg} && pred_reg)
                begin
                    f_wr = 1'b1;
                    f_wl = (W + 1)'({1'b0, fl} + {1'b0, bln_reg}
                        + (succ_reg ? {1'b0, sln_reg} : '0));
                end
                else if (fu && {1'b0, fs} == bend[W:0] && succ_reg)
                begin
                    f_wr = 1'b1;
                    if (pred_reg)
                    begin
                        f_wu = 1'b0;
                    end
                    else
                    begin
                        f_ws = bst_reg;
                        f_wl = (W + 1)'({1'b0, fl} + {1'b0, bln_reg});
                    end
                end
                else if (!fu && !pred_reg && !succ_reg && !done_reg)
                begin
                    done_next = 1'b1;
                    f_wr = 1'b1;
                    f_wu = 1'b1;
                    f_ws = bst_reg;
                    f_wl = bln_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FREE_ENTRIES - 1))
                begin
                    cnt_next = '0;
                    done_next = 1'b0;
                    state_next = S_LCLR;
                end
            end
            // Retire the live entry
            S_LCLR:
            begin
                l_shift = 1'b1;
                if (lu && !done_reg && lkey == lo_reg)
                begin
                    done_next = 1'b1;
                    l_wr = 1'b1;
                    l_wu = 1'b0;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LIVE_ENTRIES - 1))
                begin
                    rst_next = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        fnd_reg <= fnd_next;
        bst_reg <= bst_next;
        bln_reg <= bln_next;
        slot_reg <= slot_next;
        pred_reg <= pred_next;
        succ_reg <= succ_next;
        sln_reg <= sln_next;
        done_reg <= done_next;
        raddr_reg <= raddr_next;
        rstat_reg <= rst_next;
        if (state_reg == S_IDLE && req.valid)
        begin
            act_reg <= req.action;
            lo_reg <= W'(req.block_address);
            need_reg <= ({2'b0, W'(req.request_size)} + HDR == '0) ? (W + 2)'(1)
                : ({2'b0, W'(req.request_size)} + HDR);
        end
    end

    assign oaddr_reg = raddr_reg;
    assign ost_reg = rstat_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.address = REQ_W'(oaddr_reg);
    assign rsp.status = (act_reg == ACT_FREE || act_reg == ACT_ALLOC) ? ost_reg : ost_reg;
endmodule
